// ===== rtl/csd_pkg.sv =====
// Shared constants, widths and tone tables for the carrier SNR detector.
// No dependencies; every other file imports this package.
package csd_pkg;

  localparam int SAMPLE_W          = 16;
  localparam int SNR_W             = 32;
  localparam int SAMPLES_PER_CYCLE = 10;
  localparam int WINDOW_SAMPLES    = 50;
  localparam int TAB_LEN           = 10;
  localparam int PHASE_W           = $clog2(SAMPLES_PER_CYCLE);
  localparam int TAB_W             = $clog2(TAB_LEN);
  localparam int WCNT_W            = $clog2(WINDOW_SAMPLES);
  localparam int SUM_W             = 38;
  localparam int S1_W              = 22;
  localparam int SPLIT             = 19;
  localparam int MUL_W             = 20;
  localparam int PROD_W            = 2 * MUL_W;
  localparam int ACC_W             = 76;
  localparam int E_SHIFT           = 14;
  localparam int E_W               = ACC_W - E_SHIFT;
  localparam int D_W               = 44;
  localparam int DIV_W             = D_W + SNR_W;
  localparam int QCNT_W            = $clog2(SNR_W);

  localparam logic [SNR_W-1:0] THRESH_RESET = 32'h0001_0000;
  localparam logic [SNR_W-1:0] SNR_MAX      = '1;

  function automatic logic signed [15:0] cos_lut(input logic [TAB_W-1:0] k);
    logic signed [15:0] r;
    case (k)
      4'd0:    r = 16'sd32767;
      4'd1:    r = 16'sd26510;
      4'd2:    r = 16'sd10126;
      4'd3:    r = -16'sd10126;
      4'd4:    r = -16'sd26510;
      4'd5:    r = -16'sd32768;
      4'd6:    r = -16'sd26510;
      4'd7:    r = -16'sd10126;
      4'd8:    r = 16'sd10126;
      4'd9:    r = 16'sd26510;
      default: r = 16'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [15:0] sin_lut(input logic [TAB_W-1:0] k);
    logic signed [15:0] r;
    case (k)
      4'd0:    r = 16'sd0;
      4'd1:    r = 16'sd19261;
      4'd2:    r = 16'sd31164;
      4'd3:    r = 16'sd31164;
      4'd4:    r = 16'sd19261;
      4'd5:    r = 16'sd0;
      4'd6:    r = -16'sd19261;
      4'd7:    r = -16'sd31164;
      4'd8:    r = -16'sd31164;
      4'd9:    r = -16'sd19261;
      default: r = 16'sd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/csd_if.sv =====
// Valid/ready channel interfaces for the sample input and the SNR result.
// Depends on csd_pkg for field widths.
interface csd_in_if import csd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface csd_out_if import csd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SNR_W-1:0] snr;
  logic             carrier_detected;
  logic             window_end;

  modport source (output valid, output snr, output carrier_detected, output window_end,
                  input ready);
  modport sink   (input valid, input snr, input carrier_detected, input window_end,
                  output ready);
endinterface

// ===== rtl/csd_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on csd_pkg for operand widths.
module csd_mul import csd_pkg::*; (
  input  logic                     clk,
  input  logic signed [MUL_W-1:0]  op_a,
  input  logic signed [MUL_W-1:0]  op_b,
  output logic signed [PROD_W-1:0] prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

endmodule

// ===== rtl/csd_div.sv =====
// Restoring divider, one quotient bit per cycle, with Q16.16 saturation.
// Depends on csd_pkg for widths and the saturation value.
module csd_div import csd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [E_W-1:0]   dividend,
  input  logic [D_W-1:0]   divisor,
  output logic             done_r,
  output logic [SNR_W-1:0] quot_r
);

  logic              busy_r, chk_r;
  logic [E_W-1:0]    rem_r;
  logic [DIV_W-1:0]  dv_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              ge;

  assign ge = {{(DIV_W-E_W){1'b0}}, rem_r} >= dv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      chk_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r <= dividend;
        dv_r  <= {divisor, {SNR_W{1'b0}}};
        cnt_r <= QCNT_W'(SNR_W - 1);
        quot_r <= '0;
        if (divisor == '0) begin
          quot_r <= (dividend != '0) ? SNR_MAX : '0;
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
          chk_r  <= 1'b1;
        end
      end else if (busy_r && chk_r) begin
        chk_r <= 1'b0;
        dv_r  <= dv_r >> 1;
        if (ge) begin
          quot_r <= SNR_MAX;
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end else if (busy_r) begin
        if (ge) begin
          rem_r <= rem_r - dv_r[E_W-1:0];
        end
        quot_r <= {quot_r[SNR_W-2:0], ge};
        dv_r   <= dv_r >> 1;
        cnt_r  <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/carrier_snr_detector.sv =====
// Carrier SNR detector top level: sequencer, window sums and output register.
// Depends on csd_pkg, csd_if, csd_mul and csd_div.
//
// Each accepted sample is correlated against a ten-entry cosine/sine table
// and folded into window sums; after every 50 samples the block forms the
// tone power over the sample variance as unsigned Q16.16 and holds it. An
// ordinary sample passes its three products through the single shared
// multiplier before its result is loaded. The sample that closes a window
// also takes 11 more multiplier passes to build the power and variance
// terms, then the divider resolves one quotient bit per cycle over 32 bits
// plus a range check; it ends sooner when the variance is zero or the
// quotient saturates. The block takes no new sample until the result of the
// current one has been loaded into the output register.
module carrier_snr_detector import csd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  csd_in_if.sink           in_ch,
  csd_out_if.source        out_ch,
  input  logic             cfg_wr_en,
  input  logic [SNR_W-1:0] cfg_wr_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SMP  = 3'd1;
  localparam logic [2:0] ST_PWR  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  localparam logic [3:0] SP_COS = 4'd0;
  localparam logic [3:0] SP_SIN = 4'd1;
  localparam logic [3:0] SP_SQR = 4'd2;
  localparam logic [3:0] SP_ILL = 4'd3;
  localparam logic [3:0] SP_IHL = 4'd4;
  localparam logic [3:0] SP_IHH = 4'd5;
  localparam logic [3:0] SP_QLL = 4'd6;
  localparam logic [3:0] SP_QHL = 4'd7;
  localparam logic [3:0] SP_QHH = 4'd8;
  localparam logic [3:0] SP_SLO = 4'd9;
  localparam logic [3:0] SP_SHI = 4'd10;
  localparam logic [3:0] SP_FLL = 4'd11;
  localparam logic [3:0] SP_FHL = 4'd12;
  localparam logic [3:0] SP_FHH = 4'd13;

  logic [2:0]          state_r;
  logic [3:0]          cnt_r, p_step_r;
  logic                p_vld_r;
  logic [SAMPLE_W-1:0] v_r;
  logic [TAB_W-1:0]    k_r;
  logic [TAB_W-1:0]    tab_k_r;
  logic [PHASE_W-1:0]  phase_r;
  logic [WCNT_W-1:0]   wcnt_r;
  logic                close_r;
  logic [SUM_W-1:0]    sum_i_r, sum_q_r, sum_s_r;
  logic [S1_W-1:0]     sum_v_r;
  logic [ACC_W-1:0]    acc_r, acc_nxt;
  logic [E_W-1:0]      e_r;
  logic [SNR_W-1:0]    held_r, thr_r;
  logic                div_start_r;
  logic                out_valid_r, out_det_r, out_wend_r;
  logic [SNR_W-1:0]    out_snr_r;

  logic                     in_fire, iss;
  logic signed [MUL_W-1:0]  op_a, op_b;
  logic signed [PROD_W-1:0] prod_r;
  logic [SUM_W-1:0]         mag_i, mag_q;
  logic [ACC_W-1:0]         addend, base;
  logic                     neg;
  logic                     div_done;
  logic [SNR_W-1:0]         div_quot;
  logic                     out_free;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign out_ch.valid            = out_valid_r;
  assign out_ch.snr              = out_snr_r;
  assign out_ch.carrier_detected = out_det_r;
  assign out_ch.window_end       = out_wend_r;

  assign mag_i = sum_i_r[SUM_W-1] ? (~sum_i_r + 1'b1) : sum_i_r;
  assign mag_q = sum_q_r[SUM_W-1] ? (~sum_q_r + 1'b1) : sum_q_r;

  assign iss = ((state_r == ST_SMP) && (cnt_r <= SP_SQR)) ||
               ((state_r == ST_PWR) && (cnt_r <= SP_FHH));

  always_comb begin
    op_a = '0;
    op_b = '0;
    if (iss) begin
      case (cnt_r)
        SP_COS: begin
          op_a = MUL_W'(cos_lut(tab_k_r));
          op_b = {{(MUL_W-SAMPLE_W){1'b0}}, v_r};
        end
        SP_SIN: begin
          op_a = MUL_W'(sin_lut(tab_k_r));
          op_b = {{(MUL_W-SAMPLE_W){1'b0}}, v_r};
        end
        SP_SQR: begin
          op_a = {{(MUL_W-SAMPLE_W){1'b0}}, v_r};
          op_b = {{(MUL_W-SAMPLE_W){1'b0}}, v_r};
        end
        SP_ILL: begin
          op_a = {1'b0, mag_i[SPLIT-1:0]};
          op_b = {1'b0, mag_i[SPLIT-1:0]};
        end
        SP_IHL: begin
          op_a = {1'b0, mag_i[SUM_W-1:SPLIT]};
          op_b = {1'b0, mag_i[SPLIT-1:0]};
        end
        SP_IHH: begin
          op_a = {1'b0, mag_i[SUM_W-1:SPLIT]};
          op_b = {1'b0, mag_i[SUM_W-1:SPLIT]};
        end
        SP_QLL: begin
          op_a = {1'b0, mag_q[SPLIT-1:0]};
          op_b = {1'b0, mag_q[SPLIT-1:0]};
        end
        SP_QHL: begin
          op_a = {1'b0, mag_q[SUM_W-1:SPLIT]};
          op_b = {1'b0, mag_q[SPLIT-1:0]};
        end
        SP_QHH: begin
          op_a = {1'b0, mag_q[SUM_W-1:SPLIT]};
          op_b = {1'b0, mag_q[SUM_W-1:SPLIT]};
        end
        SP_SLO: begin
          op_a = MUL_W'(WINDOW_SAMPLES);
          op_b = {1'b0, sum_s_r[SPLIT-1:0]};
        end
        SP_SHI: begin
          op_a = MUL_W'(WINDOW_SAMPLES);
          op_b = {1'b0, sum_s_r[SUM_W-1:SPLIT]};
        end
        SP_FLL: begin
          op_a = {1'b0, sum_v_r[SPLIT-1:0]};
          op_b = {1'b0, sum_v_r[SPLIT-1:0]};
        end
        SP_FHL: begin
          op_a = {{(MUL_W-S1_W+SPLIT){1'b0}}, sum_v_r[S1_W-1:SPLIT]};
          op_b = {1'b0, sum_v_r[SPLIT-1:0]};
        end
        SP_FHH: begin
          op_a = {{(MUL_W-S1_W+SPLIT){1'b0}}, sum_v_r[S1_W-1:SPLIT]};
          op_b = {{(MUL_W-S1_W+SPLIT){1'b0}}, sum_v_r[S1_W-1:SPLIT]};
        end
        default: begin
          op_a = '0;
          op_b = '0;
        end
      endcase
    end
  end

  csd_mul u_mul (
    .clk    (clk),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (prod_r)
  );

  always_comb begin
    case (p_step_r)
      SP_IHL, SP_QHL, SP_FHL: addend = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r} << (SPLIT + 1);
      SP_IHH, SP_QHH, SP_FHH: addend = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r} << (2 * SPLIT);
      SP_SHI:                 addend = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r} << SPLIT;
      default:                addend = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
    endcase
    neg     = (p_step_r == SP_FLL) || (p_step_r == SP_FHL) || (p_step_r == SP_FHH);
    base    = ((p_step_r == SP_ILL) || (p_step_r == SP_SLO)) ? '0 : acc_r;
    acc_nxt = neg ? (base - addend) : (base + addend);
  end

  csd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (e_r),
    .divisor  (acc_r[D_W-1:0]),
    .done_r   (div_done),
    .quot_r   (div_quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      p_vld_r     <= 1'b0;
      p_step_r    <= '0;
      k_r         <= '0;
      tab_k_r     <= '0;
      phase_r     <= '0;
      wcnt_r      <= '0;
      close_r     <= 1'b0;
      sum_i_r     <= '0;
      sum_q_r     <= '0;
      sum_s_r     <= '0;
      sum_v_r     <= '0;
      held_r      <= '0;
      thr_r       <= THRESH_RESET;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      div_start_r <= 1'b0;
      p_vld_r     <= iss;
      p_step_r    <= cnt_r;
      if (iss) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (cfg_wr_en) begin
        thr_r <= cfg_wr_data;
      end
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      if (p_vld_r) begin
        case (p_step_r)
          SP_COS:  sum_i_r <= sum_i_r + prod_r[SUM_W-1:0];
          SP_SIN:  sum_q_r <= sum_q_r + prod_r[SUM_W-1:0];
          SP_SQR:  sum_s_r <= sum_s_r + prod_r[SUM_W-1:0];
          default: acc_r   <= acc_nxt;
        endcase
        if (p_step_r == SP_SLO) begin
          e_r <= acc_r[ACC_W-1:E_SHIFT];
        end
      end

      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            v_r     <= in_ch.sample;
            tab_k_r <= k_r;
            sum_v_r <= sum_v_r + {{(S1_W-SAMPLE_W){1'b0}}, in_ch.sample};
            cnt_r   <= SP_COS;
            if (phase_r == PHASE_W'(SAMPLES_PER_CYCLE - 1)) begin
              phase_r <= '0;
              k_r     <= '0;
            end else begin
              phase_r <= phase_r + 1'b1;
              k_r     <= (k_r == TAB_W'(TAB_LEN - 1)) ? '0 : k_r + 1'b1;
            end
            if (wcnt_r == WCNT_W'(WINDOW_SAMPLES - 1)) begin
              wcnt_r  <= '0;
              close_r <= 1'b1;
            end else begin
              wcnt_r  <= wcnt_r + 1'b1;
              close_r <= 1'b0;
            end
            state_r <= ST_SMP;
          end
        end
        ST_SMP: begin
          if (p_vld_r && (p_step_r == SP_SQR)) begin
            state_r <= close_r ? ST_PWR : ST_OUT;
          end
        end
        ST_PWR: begin
          if (p_vld_r && (p_step_r == SP_FHH)) begin
            div_start_r <= 1'b1;
            state_r     <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            held_r  <= div_quot;
            sum_i_r <= '0;
            sum_q_r <= '0;
            sum_s_r <= '0;
            sum_v_r <= '0;
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_snr_r   <= held_r;
            out_det_r   <= held_r > thr_r;
            out_wend_r  <= close_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for carrier_snr_detector: sample windows, tone power over variance.
// Depends on csd_pkg and the csd_in_if/csd_out_if channel interfaces.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import csd_pkg::*;

  localparam int CYCLE_LEN  = 10;
  localparam int WINDOW_LEN = 50;
  localparam int PHASES     = 7;
  localparam int WINDOWS_PER_PHASE = 4;
  localparam int SETTLE_CYCLES = 64;

  typedef enum int {WIN_FLAT, WIN_TONE, WIN_SPIKE, WIN_NOISE, WIN_RAIL} window_kind_e;

  typedef struct packed {
    logic [SNR_W-1:0] snr;
    logic             detected;
    logic             closed;
  } snr_result_t;

  class snr_scoreboard;
    logic [SNR_W-1:0] threshold;
    logic [SNR_W-1:0] held;
    int               phase;
    int               count;
    longint           sum_i;
    longint           sum_q;
    longint unsigned  sum_sq;
    longint unsigned  sum_v;
    snr_result_t      expected_q[$];
    int               errors;

    function new();
      threshold = 32'h0001_0000;
      held      = '0;
      phase     = 0;
      count     = 0;
      sum_i     = 0;
      sum_q     = 0;
      sum_sq    = 0;
      sum_v     = 0;
      errors    = 0;
    endfunction

    function int cos_q15(int k);
      case (k)
        0: return 32767;
        1: return 26510;
        2: return 10126;
        3: return -10126;
        4: return -26510;
        5: return -32768;
        6: return -26510;
        7: return -10126;
        8: return 10126;
        9: return 26510;
        default: return 0;
      endcase
    endfunction

    function int sin_q15(int k);
      case (k)
        1, 4: return 19261;
        2, 3: return 31164;
        6, 9: return -19261;
        7, 8: return -31164;
        default: return 0;
      endcase
    endfunction

    function logic [SNR_W-1:0] window_snr();
      logic [127:0]    mag_i;
      logic [127:0]    mag_q;
      logic [127:0]    power;
      logic [127:0]    quo;
      longint unsigned spread;
      mag_i  = 128'(sum_i < 0 ? -sum_i : sum_i);
      mag_q  = 128'(sum_q < 0 ? -sum_q : sum_q);
      power  = (mag_i * mag_i + mag_q * mag_q) >> 14;
      spread = longint'(WINDOW_LEN) * sum_sq - sum_v * sum_v;
      if (spread == 0) return (power != 0) ? '1 : '0;
      quo = power / 128'(spread);
      if (quo[127:32] != 0) return '1;
      return quo[31:0];
    endfunction

    function void note_sample(logic [SAMPLE_W-1:0] v);
      logic closed;
      sum_i  += longint'(cos_q15(phase % CYCLE_LEN)) * longint'(v);
      sum_q  += longint'(sin_q15(phase % CYCLE_LEN)) * longint'(v);
      sum_sq += longint'(v) * longint'(v);
      sum_v  += longint'(v);
      phase   = (phase + 1 >= CYCLE_LEN) ? 0 : phase + 1;
      count++;
      closed  = 1'b0;
      if (count >= WINDOW_LEN) begin
        held   = window_snr();
        closed = 1'b1;
        count  = 0;
        sum_i  = 0;
        sum_q  = 0;
        sum_sq = 0;
        sum_v  = 0;
      end
      expected_q.push_back('{held, held > threshold, closed});
    endfunction

    function void check_result(logic [SNR_W-1:0] snr, logic detected, logic closed);
      snr_result_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result: snr=%h carrier_detected=%b window_end=%b",
               snr, detected, closed);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (snr !== want.snr) begin
        $error("snr: expected %h, got %h", want.snr, snr);
        errors++;
      end
      if (detected !== want.detected) begin
        $error("carrier_detected: expected %b, got %b", want.detected, detected);
        errors++;
      end
      if (closed !== want.closed) begin
        $error("window_end: expected %b, got %b", want.closed, closed);
        errors++;
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [SNR_W-1:0] cfg_wr_data;
  logic             in_quiet  = 1'b0;
  logic             out_quiet = 1'b0;
  int               sent      = 0;
  snr_scoreboard    sb        = new();

  csd_in_if  in_ch ();
  csd_out_if out_ch ();

  carrier_snr_detector dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic send_sample(input logic [SAMPLE_W-1:0] v);
    int gap;
    gap = in_quiet ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_sample(v);
    sent++;
  endtask

  task automatic send_window(input window_kind_e kind, input int level);
    int n;
    int base;
    int amp;
    int turn;
    int nz;
    int p1;
    int p2;
    int delta;
    int value;
    n     = WINDOW_LEN - (sent % WINDOW_LEN);
    base  = (level >= 0) ? level : $urandom_range(0, 65535);
    if (kind == WIN_FLAT && level < 0) begin
      case ($urandom_range(0, 3))
        0:       base = 0;
        1:       base = 1;
        2:       base = 65535;
        default: base = $urandom_range(0, 65535);
      endcase
    end
    amp   = $urandom_range(0, 32767);
    turn  = $urandom_range(0, CYCLE_LEN - 1);
    nz    = $urandom_range(0, 1) ? $urandom_range(0, 64) : $urandom_range(0, 8192);
    p1    = $urandom_range(0, n - 1);
    p2    = $urandom_range(0, n - 1);
    delta = $urandom_range(1, 300);
    in_quiet  = ($urandom_range(0, 3) == 0);
    out_quiet = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n; i++) begin
      case (kind)
        WIN_FLAT:  value = base;
        WIN_TONE:  value = base + amp * sb.cos_q15((sent + turn) % CYCLE_LEN) / 32768
                           + int'($urandom_range(0, 2 * nz)) - nz;
        WIN_SPIKE: value = base + ((i == p1) ? delta : 0) - ((i == p2) ? delta / 2 : 0);
        WIN_RAIL:  value = $urandom_range(0, 1) ? 65535 : 0;
        default:   value = $urandom_range(0, 65535);
      endcase
      if (value < 0) value = 0;
      if (value > 65535) value = 65535;
      send_sample(value[SAMPLE_W-1:0]);
    end
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [SNR_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.threshold = v;
  endtask

  initial begin
    logic [SAMPLE_W-1:0] corner_samples [9];
    window_kind_e        first_kinds [WINDOWS_PER_PHASE];
    int                  first_levels [WINDOWS_PER_PHASE];
    logic [SNR_W-1:0]    limit;
    corner_samples = '{16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA, 16'hFFFF,
                       16'h0000, 16'h8000, 16'h7FFF, 16'h0001};
    first_kinds    = '{WIN_FLAT, WIN_FLAT, WIN_SPIKE, WIN_TONE};
    first_levels   = '{65535, 1, 40000, -1};
    rst_n        <= 1'b0;
    cfg_wr_en    <= 1'b0;
    cfg_wr_data  <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.sample <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < SAMPLE_W; i++) send_sample(16'h0001 << i);
    foreach (corner_samples[i]) send_sample(corner_samples[i]);
    send_window(WIN_NOISE, -1);

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        drain_results();
        case (ph)
          1:       limit = '0;
          2:       limit = '1;
          3:       limit = sb.held;
          4:       limit = sb.held - 1;
          5:       limit = $urandom_range(0, 32'h0002_0000);
          default: limit = $urandom();
        endcase
        write_threshold(limit);
      end
      for (int w = 0; w < WINDOWS_PER_PHASE; w++) begin
        if (ph == 0) send_window(first_kinds[w], first_levels[w]);
        else send_window(window_kind_e'($urandom_range(0, 4)), -1);
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = out_quiet ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      sb.check_result(out_ch.snr, out_ch.carrier_detected, out_ch.window_end);
    end
  end

  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/csd_pkg.sv
rtl/csd_if.sv
rtl/csd_mul.sv
rtl/csd_div.sv
rtl/carrier_snr_detector.sv
dv/testbench.sv
